// ===== hw/rtl/distance_vector_route_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Route table core assertion macros
// Concurrent property wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define DVRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define DVRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define DVRT_ASSERT_IMPL(label, clk, rst, ante, cons)

`define DVRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Route table core package
// Field widths, fixed-point constants, command and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

   localparam int DATA_W    = 24;
   localparam int LINK_W    = 6;
   localparam int NODE_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int SCALE_W   = 18;
   localparam int NUM_W     = DATA_W + SCALE_W;
   localparam int CNT_W     = $clog2(DATA_W);

   localparam logic [DATA_W-1:0]  MAX_DIST     = '1;
   localparam logic [SCALE_W-1:0] WEIGHT_SCALE = 18'd256000;

   typedef enum logic [1:0] {
      CMD_HOST   = 2'd0,
      CMD_ADV    = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SELF_ID   = 2'd0,
      CSR_TOLERANCE = 2'd1
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hw/rtl/distance_vector_route_table_core.sv =====
// ----------------------------------------------------------------------------
// Distance vector route table core
// Host route, lookup and unused commands are answered out of S_FETCH; an
// advertisement entry goes on through S_WAIT, where the 24-step radix-2 link
// weight divider runs, then S_OFFER and S_DECIDE. A new word is taken only in
// S_IDLE and busy is high in all other states; the result never waits, since the receiver cannot stall.
// Reset is synchronous and empties the table at once (per-entry valid flops).
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_vector_route_table_core_defines.svh"

module distance_vector_route_table_core
   import dvrt_pkg::*;
#(
   parameter int NODES = 256,
   parameter int LINKS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_command,
   input  wire logic [NODE_W-1:0]    req_dest_id,
   input  wire logic [DATA_W-1:0]    req_adv_distance,
   input  wire logic [LINK_W-1:0]    req_link_id,
   input  wire logic [DATA_W-1:0]    req_link_delay,
   input  wire logic [DATA_W-1:0]    req_link_occupancy,
   input  wire logic [DATA_W-1:0]    req_link_rate,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   output logic [LINK_W-1:0]         rsp_next_link,
   output logic                      rsp_found,
   output logic                      rsp_entry_written,
   output logic                      rsp_table_changed,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH = (NODES < 256) ? NODES : 256;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENT_W = DATA_W + LINK_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_FETCH  = 5'b00010,
      S_WAIT   = 5'b00100,
      S_OFFER  = 5'b01000,
      S_DECIDE = 5'b10000
   } state_type;

   state_type          state_ff, state_in;

   logic [NODE_W-1:0]  self_id_ff;
   logic [DATA_W-1:0]  tol_ff;

   cmd_type            cmd_ff;
   logic [NODE_W-1:0]  dest_ff;
   logic [DATA_W-1:0]  adv_ff;
   logic [LINK_W-1:0]  link_ff;
   logic [DATA_W-1:0]  delay_ff;
   logic [DATA_W-1:0]  occ_ff;
   logic [DATA_W-1:0]  rate_ff;
   logic               last_ff;

   logic [ENT_W-1:0]   route_mem [DEPTH];
   logic [DATA_W-1:0]  rd_dist_ff;
   logic [LINK_W-1:0]  rd_link_ff;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic               change_seen_ff, change_seen_in;

   logic [DATA_W-1:0]  weight_ff;
   logic [DATA_W:0]    offer_ff;

   logic               rsp_valid_ff;
   logic [LINK_W-1:0]  rsp_next_link_ff;
   logic               rsp_found_ff;
   logic               rsp_written_ff;
   logic               rsp_changed_ff;

   logic               accept;
   logic [AW-1:0]      idx;
   logic [AW-1:0]      req_idx;
   logic               in_range;
   logic               usable;
   logic               entry_valid;
   logic               div_start;
   logic               div_done;
   logic [DATA_W-1:0]  div_quo;
   logic [DATA_W:0]    weight_sum;
   logic [DATA_W+1:0]  offer_tol;
   logic [DATA_W:0]    dist_tol;
   logic               better;
   logic               worse;
   logic               take;
   logic               wr_en;
   logic [ENT_W-1:0]   wr_data;

   assign busy      = !state_ff[0];
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign idx         = dest_ff[AW-1:0];
   assign req_idx     = req_dest_id[AW-1:0];
   assign in_range    = 32'(dest_ff) < NODES;
   assign usable      = in_range && (dest_ff != self_id_ff) && (32'(link_ff) < LINKS);
   assign entry_valid = valid_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff <= '0;
         tol_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SELF_ID:   self_id_ff <= csr_wdata[NODE_W-1:0];
            CSR_TOLERANCE: tol_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_command);
         dest_ff  <= req_dest_id;
         adv_ff   <= req_adv_distance;
         link_ff  <= req_link_id;
         delay_ff <= req_link_delay;
         occ_ff   <= req_link_occupancy;
         rate_ff  <= req_link_rate;
         last_ff  <= req_last;
      end
   end

   assign div_start = (state_ff == S_FETCH) && (cmd_ff == CMD_ADV);

   dvrt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .occupancy (occ_ff),
      .rate      (rate_ff),
      .done      (div_done),
      .quotient  (div_quo)
   );

   assign weight_sum = {1'b0, delay_ff} + {1'b0, div_quo};
   assign offer_tol  = {1'b0, offer_ff} + {2'b00, tol_ff};
   assign dist_tol   = {1'b0, rd_dist_ff} + {1'b0, tol_ff};
   assign better     = {2'b00, rd_dist_ff} > offer_tol;
   assign worse      = dist_tol < offer_ff;
   assign take       = usable && (!entry_valid || better || (worse && rd_link_ff == link_ff)
                       || (!better && !worse && link_ff < rd_link_ff));

   always_ff @(posedge clock) begin
      if (state_ff == S_WAIT) begin
         weight_ff <= weight_sum[DATA_W] ? MAX_DIST : weight_sum[DATA_W-1:0];
      end
      if (state_ff == S_OFFER) begin
         offer_ff <= {1'b0, adv_ff} + {1'b0, weight_ff};
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_data = {delay_ff, link_ff};
      priority if (state_ff == S_FETCH && cmd_ff == CMD_HOST && usable) begin
         wr_en = 1'b1;
      end else if (state_ff == S_DECIDE && take) begin
         wr_en   = 1'b1;
         wr_data = {(offer_ff[DATA_W] ? MAX_DIST : offer_ff[DATA_W-1:0]), link_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[idx] <= wr_data;
      end
      if (accept) begin
         {rd_dist_ff, rd_link_ff} <= route_mem[req_idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[idx] = 1'b1;
      end
   end

   always_comb begin
      change_seen_in = change_seen_ff;
      if (state_ff == S_DECIDE) begin
         change_seen_in = last_ff ? 1'b0 : (change_seen_ff || take);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_FETCH;
         S_FETCH:  state_in = (cmd_ff == CMD_ADV) ? S_WAIT : S_IDLE;
         S_WAIT:   if (div_done) state_in = S_OFFER;
         S_OFFER:  state_in = S_DECIDE;
         S_DECIDE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         valid_ff       <= '0;
         change_seen_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         change_seen_ff <= change_seen_in;
         rsp_valid_ff   <= (state_ff == S_FETCH && cmd_ff != CMD_ADV)
                           || (state_ff == S_DECIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FETCH) begin
         rsp_found_ff     <= 1'b0;
         rsp_next_link_ff <= '0;
         rsp_written_ff   <= 1'b0;
         rsp_changed_ff   <= 1'b0;
         if (cmd_ff == CMD_LOOKUP && in_range && dest_ff != self_id_ff && entry_valid) begin
            rsp_found_ff     <= 1'b1;
            rsp_next_link_ff <= rd_link_ff;
         end
      end else if (state_ff == S_DECIDE) begin
         rsp_found_ff     <= 1'b0;
         rsp_next_link_ff <= '0;
         rsp_written_ff   <= take;
         rsp_changed_ff   <= last_ff && (change_seen_ff || take);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_link     = rsp_next_link_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_entry_written = rsp_written_ff;
   assign rsp_table_changed = rsp_changed_ff;

   `DVRT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `DVRT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_valid_ff)
   `DVRT_ASSERT_IMPL(a_div_done_wait, clock, reset, div_done, state_ff == S_WAIT)
   `DVRT_ASSERT_IMPL(a_write_usable, clock, reset, wr_en, usable && busy)

endmodule

`default_nettype wire

// ===== hw/rtl/dvrt_div.sv =====
// ----------------------------------------------------------------------------
// Link weight divider
// Scales occupancy by 256000 and divides by rate one quotient bit per cycle,
// saturating at the 24-bit maximum. Operands must hold until done.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_div
   import dvrt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] occupancy,
   input  wire logic [DATA_W-1:0] rate,
   output logic                   done,
   output logic [DATA_W-1:0]      quotient
);

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_MUL  = 4'b0010,
      D_LOAD = 4'b0100,
      D_DIV  = 4'b1000
   } div_state_type;

   div_state_type      state_ff, state_in;
   logic [NUM_W-1:0]   num_ff;
   logic [DATA_W-1:0]  rem_ff;
   logic [DATA_W-1:0]  quo_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               sat_ff;
   logic               done_ff;
   logic [DATA_W+1:0]  trial;

   assign trial = {1'b0, rem_ff, quo_ff[DATA_W-1]} - {2'b00, rate};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         D_IDLE: if (start) state_in = D_MUL;
         D_MUL:  state_in = D_LOAD;
         D_LOAD: state_in = D_DIV;
         D_DIV:  if (cnt_ff == '0) state_in = D_IDLE;
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == D_DIV) && (cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         D_MUL: begin
            num_ff <= NUM_W'(occupancy) * NUM_W'(WEIGHT_SCALE);
         end
         D_LOAD: begin
            sat_ff <= {{(DATA_W-SCALE_W){1'b0}}, num_ff[NUM_W-1:DATA_W]} >= rate;
            rem_ff <= {{(DATA_W-SCALE_W){1'b0}}, num_ff[NUM_W-1:DATA_W]};
            quo_ff <= num_ff[DATA_W-1:0];
            cnt_ff <= CNT_W'(DATA_W - 1);
         end
         D_DIV: begin
            if (!trial[DATA_W+1]) begin
               rem_ff <= trial[DATA_W-1:0];
            end else begin
               rem_ff <= {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            end
            quo_ff <= {quo_ff[DATA_W-2:0], ~trial[DATA_W+1]};
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? MAX_DIST : quo_ff;

endmodule

`default_nettype wire
